// ----- design/lzss_pkg.sv -----
// Package for the LZSS stream decoder: shared constants and the work record type.
// No dependencies.
package lzss_pkg;

  localparam int unsigned HistoryDepthDefault = 65536;
  localparam logic [3:0]  MatchBiasReset      = 4'd3;
  localparam logic [3:0]  MatchBiasMax        = 4'd8;
  localparam logic [7:0]  VersionWide         = 8'h02;
  localparam logic [3:0]  NibbleMask          = 4'hF;
  localparam int unsigned QueueDepth          = 4;

  // One unit of work handed from the parser to the copy engine.
  // Kind codes.
  typedef enum logic [1:0] {
    JOB_LIT  = 2'd0,
    JOB_COPY = 2'd1,
    JOB_BAD  = 2'd2,
    JOB_NONE = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  lit;
    logic [16:0] offset;
    logic [8:0]  length;   // already clipped to the bytes still owed
  } job_t;

endpackage

// ----- design/lzss_if.sv -----
// Valid/ready channel interface used by every stream port of the decoder.
// Depends on nothing; payload type is a parameter.
interface lzss_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/lzss_stream_decoder_unit.sv -----
// LZSS stream decoder top level. One input beat per cycle when the job queue
// has room; a literal result passes through the job queue and the back end's
// output register, and the back end takes no new literal while the previous
// result is still offered. A copy holds the back end for a pop, one RAM read and
// one write per byte, and one emit per beat of up to eight bytes. Synchronous
// reset clears parser, queue and engine; history RAM contents are not cleared.
module lzss_stream_decoder_unit #(
  parameter int HistoryDepth = lzss_pkg::HistoryDepthDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic [3:0] cfg_wdata,
  lzss_if.sink  in_ch,
  lzss_if.source out_ch
);
  import lzss_pkg::*;

  logic [3:0] match_bias;
  job_t       f_job, q_job;
  logic       f_valid, q_full, q_empty, q_pop;

  // configuration register, saturated to eight
  always_ff @(posedge clk) begin
    if (rst) match_bias <= MatchBiasReset;
    else if (cfg_we) match_bias <= (cfg_wdata > MatchBiasMax) ? MatchBiasMax : cfg_wdata;
  end

  lzss_front #(.HistoryDepth(HistoryDepth)) u_front (
    .clk(clk), .rst(rst), .match_bias(match_bias),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.data.in_byte), .in_last(in_ch.data.in_last),
    .job_valid(f_valid), .job_ready(!q_full), .job(f_job)
  );

  lzss_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(f_valid && f_job.kind != JOB_NONE),
    .push_job(f_job), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head_job(q_job)
  );

  lzss_back #(.HistoryDepth(HistoryDepth)) u_back (
    .clk(clk), .rst(rst), .job_empty(q_empty), .job(q_job),
    .job_pop(q_pop), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_bytes(out_ch.data.out_bytes), .out_count(out_ch.data.out_count),
    .out_status(out_ch.data.out_status), .run_last(out_ch.data.run_last)
  );
endmodule

// ----- design/lzss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lzss_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/lzss_front.sv -----
// Front end: parses header, version, flag and token bytes into jobs.
// Depends on lzss_pkg.
module lzss_front #(
  parameter int HistoryDepth = lzss_pkg::HistoryDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        match_bias,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              job_valid,
  input  logic              job_ready,
  output lzss_pkg::job_t    job
);
  import lzss_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_VERSION, PH_FLAG, PH_TOKEN, PH_MATCH2, PH_MATCH3, PH_DONE
  } phase_t;

  phase_t      phase;
  logic [1:0]  header_index;
  logic [31:0] original_size;
  logic [31:0] produced_count;
  logic        wide_format;
  logic [7:0]  flag_bits;
  logic [3:0]  token_index;
  logic [15:0] token_bytes;

  logic        accept;
  logic [16:0] off;
  logic [8:0]  len;
  logic [31:0] remain;
  logic [8:0]  clip;
  logic        bad;
  logic        is_match;
  logic [31:0] size_next;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign remain   = original_size - produced_count;

  // decode the match being closed by this beat
  always_comb begin
    is_match = 1'b0;
    off      = '0;
    len      = '0;
    if (phase == PH_MATCH2 && !wide_format) begin
      is_match = 1'b1;
      off = {5'd0, in_byte[3:0] & NibbleMask, token_bytes[7:0]};
      len = 9'(in_byte[7:4]) + 9'(match_bias);
    end else if (phase == PH_MATCH3) begin
      is_match = 1'b1;
      off = {1'b0, token_bytes};
      len = 9'(in_byte) + 9'(match_bias);
    end
    bad  = (off == '0) || (32'(off) > produced_count) ||
           (32'(off) > 32'(HistoryDepth));
    clip = (remain < 32'(len)) ? remain[8:0] : len;
  end

  always_comb begin
    size_next = original_size | (32'(in_byte) << {header_index, 3'b000});
  end

  // job out
  always_comb begin
    job.kind   = JOB_NONE;
    job.lit    = in_byte;
    job.offset = off;
    job.length = clip;
    if (phase == PH_TOKEN && !flag_bits[token_index[2:0]]) begin
      job.kind = JOB_LIT;
    end else if (is_match) begin
      job.kind = bad ? JOB_BAD : JOB_COPY;
    end
  end
  assign job_valid = accept;

  // parser state
  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      phase <= PH_HEADER;
      header_index <= '0;
      original_size <= '0;
      produced_count <= '0;
      wide_format <= 1'b0;
      flag_bits <= '0;
      token_index <= '0;
      token_bytes <= '0;
    end else if (accept) begin
      case (phase)
        PH_HEADER: begin
          original_size <= size_next;
          header_index <= header_index + 2'd1;
          if (header_index == 2'd3)
            phase <= (size_next == '0) ? PH_DONE : PH_VERSION;
        end
        PH_VERSION: begin
          if (in_byte == VersionWide) begin
            wide_format <= 1'b1;
            phase <= PH_FLAG;
          end else begin
            flag_bits <= in_byte;
            token_index <= '0;
            phase <= PH_TOKEN;
          end
        end
        PH_FLAG: begin
          flag_bits <= in_byte;
          token_index <= '0;
          phase <= PH_TOKEN;
        end
        PH_TOKEN: begin
          if (!flag_bits[token_index[2:0]]) begin
            produced_count <= produced_count + 32'd1;
            token_index <= token_index + 4'd1;
            if (produced_count + 32'd1 >= original_size) phase <= PH_DONE;
            else if (token_index == 4'd7) phase <= PH_FLAG;
            else phase <= PH_TOKEN;
          end else begin
            token_bytes <= {8'd0, in_byte};
            phase <= PH_MATCH2;
          end
        end
        PH_MATCH2, PH_MATCH3: begin
          if (phase == PH_MATCH2 && wide_format) begin
            token_bytes <= {in_byte, token_bytes[7:0]};
            phase <= PH_MATCH3;
          end else if (bad) begin
            phase <= PH_FLAG;
          end else begin
            produced_count <= produced_count + 32'(clip);
            token_index <= token_index + 4'd1;
            if (produced_count + 32'(clip) >= original_size) phase <= PH_DONE;
            else if (token_index == 4'd7) phase <= PH_FLAG;
            else phase <= PH_TOKEN;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- design/lzss_queue.sv -----
// Small FIFO between the parser and the copy engine.
// Depends on lzss_pkg.
module lzss_queue #(
  parameter int Depth = lzss_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lzss_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lzss_pkg::job_t head_job
);
  import lzss_pkg::*;
  localparam int AW = $clog2(Depth);

  job_t          jobs [Depth];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [AW:0]   fill;

  assign full      = (fill == (AW+1)'(Depth));
  assign empty     = (fill == '0);
  assign head_job  = jobs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      jobs[wr_ptr]  <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ----- design/lzss_back.sv -----
// Back end: executes jobs against the history RAM and packs result beats.
// Depends on lzss_pkg and lzss_ram.
module lzss_back #(
  parameter int HistoryDepth = lzss_pkg::HistoryDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_empty,
  input  lzss_pkg::job_t job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_bytes,
  output logic [3:0]     out_count,
  output logic           out_status,
  output logic           run_last
);
  import lzss_pkg::*;
  localparam int AW = $clog2(HistoryDepth);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_COPY, S_EMIT} state_t;

  state_t        state;
  logic [AW-1:0] wptr, src;
  logic [8:0]    left;
  logic [63:0]   acc;
  logic [3:0]    acc_n;
  logic          rd_pending;
  logic          flush;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, rdata;
  logic [AW-1:0] raddr;

  lzss_ram #(.Width(8), .Depth(HistoryDepth)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // writes: literal from queue head, or copied byte coming out of the RAM
  always_comb begin
    we    = 1'b0;
    waddr = wptr;
    wdata = job.lit;
    raddr = src;
    if (state == S_IDLE && !job_empty && job.kind == JOB_LIT && !out_valid) we = 1'b1;
    if (state == S_COPY && rd_pending) begin
      we = 1'b1;
      wdata = rdata;
    end
  end

  assign job_pop = state == S_IDLE && !job_empty && !out_valid;
  assign flush   = state == S_COPY && rd_pending && (acc_n == 4'd7 || left == 9'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      wptr <= '0;
      rd_pending <= 1'b0;
      acc_n <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_pop) begin
            case (job.kind)
              JOB_LIT: begin
                wptr <= wptr + 1'b1;
                out_valid <= 1'b1;
                out_bytes <= {56'd0, job.lit};
                out_count <= 4'd1;
                out_status <= 1'b0;
                run_last <= 1'b1;
              end
              JOB_BAD: begin
                out_valid <= 1'b1;
                out_bytes <= '0;
                out_count <= '0;
                out_status <= 1'b1;
                run_last <= 1'b1;
              end
              JOB_COPY: begin
                if (job.length != '0) begin
                  src <= wptr - job.offset[AW-1:0];
                  left <= job.length;
                  acc <= '0;
                  acc_n <= '0;
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        // issue one RAM read per byte; overlap sees the byte just written
        S_READ: begin
          src <= src + 1'b1;
          rd_pending <= 1'b1;
          state <= S_COPY;
        end
        S_COPY: begin
          rd_pending <= 1'b0;
          wptr <= wptr + 1'b1;
          acc <= acc | (64'(rdata) << {acc_n[2:0], 3'b000});
          acc_n <= acc_n + 4'd1;
          left <= left - 9'd1;
          if (flush) state <= S_EMIT;
          else state <= S_READ;
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_bytes <= acc;
            out_count <= acc_n;
            out_status <= 1'b0;
            run_last <= (left == '0);
            acc <= '0;
            acc_n <= '0;
            state <= (left == '0) ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/lzss_checker.sv -----
// Port-level checker for the LZSS decoder, bound to the top level.
// No dependencies of its own; the bind below targets lzss_stream_decoder_unit.
module lzss_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_count,
  input logic        out_status,
  input logic [63:0] out_bytes
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes))
    else $error("result beat dropped while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= 4'd8)
    else $error("count above eight");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_count == 4'd0 && out_bytes == 64'd0)
    else $error("status beat carries data");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind lzss_stream_decoder_unit lzss_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_count(out_ch.data.out_count), .out_status(out_ch.data.out_status),
  .out_bytes(out_ch.data.out_bytes)
);
